// ----- hdl/websocket_frame_deframer_defines.svh -----
// Assertion macros shared by the deframer RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define WSD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/wsd_pkg.sv -----
// Package with the types and constants of the WebSocket frame deframer.
`default_nettype none

package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    localparam int unsigned LEN_W = 64;

    localparam logic [3:0] OPC_CLOSE     = 4'h8;
    localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
    localparam logic [6:0] LEN_EXT16     = 7'd126;
    localparam logic [2:0] EXT16_COUNT   = 3'd1;
    localparam logic [2:0] EXT64_COUNT   = 3'd7;
    localparam logic [1:0] KEY_LAST      = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       frame_last;
        logic       close_seen;
    } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/wsd_if.sv -----
// Handshake interfaces for the received byte channel and the payload channel.
`default_nettype none

interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       restart;

    modport source (output valid, output rx_byte, output restart, input ready);
    modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_last;
    logic       close_seen;

    modport source (output valid, output payload_byte, output payload_valid,
                    output frame_last, output close_seen, input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input frame_last, input close_seen, output ready);
endinterface

`default_nettype wire

// ----- hdl/wsd_core.sv -----
// Frame parsing state and the per-byte next-state and result logic.
`default_nettype none
`include "websocket_frame_deframer_defines.svh"

module wsd_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wsd_pkg::in_item_t      item,
    output logic                   res_valid,
    output wsd_pkg::out_item_t     res
);
    import wsd_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;
    logic [2:0]         ext_cnt_reg, ext_cnt_next;
    logic               masked_reg, masked_next;
    logic [31:0]        key_reg, key_next;
    logic [1:0]         key_idx_reg, key_idx_next;
    logic               closed_reg, closed_next;

    logic               len_known;
    logic               hdr_done;
    logic [7:0]         key_byte;
    logic [7:0]         b;

    assign b = item.rx_byte;

    always_comb
    begin
        phase_next   = phase_reg;
        remain_next  = remain_reg;
        ext_cnt_next = ext_cnt_reg;
        masked_next  = masked_reg;
        key_next     = key_reg;
        key_idx_next = key_idx_reg;
        closed_next  = closed_reg;
        len_known    = 1'b0;
        hdr_done     = 1'b0;
        key_byte     = masked_reg ? key_reg[{key_idx_reg, 3'b000} +: 8] : 8'd0;
        res_valid    = 1'b0;
        res          = '0;

        if (item.restart)
        begin
            phase_next   = PH_HDR0;
            remain_next  = '0;
            ext_cnt_next = '0;
            masked_next  = 1'b0;
            key_next     = '0;
            key_idx_next = '0;
            closed_next  = 1'b0;
        end
        else if (!closed_reg)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    masked_next = b[7];
                    if (b[6:0] <= LEN_SHORT_MAX)
                    begin
                        remain_next = {{(LEN_W-7){1'b0}}, b[6:0]};
                        len_known   = 1'b1;
                    end
                    else
                    begin
                        remain_next  = '0;
                        ext_cnt_next = (b[6:0] == LEN_EXT16) ? EXT16_COUNT : EXT64_COUNT;
                        phase_next   = PH_EXT;
                    end
                end
                PH_EXT:
                begin
                    remain_next = {remain_reg[LEN_W-9:0], b};
                    if (ext_cnt_reg == 3'd0)
                    begin
                        len_known = 1'b1;
                    end
                    else
                    begin
                        ext_cnt_next = ext_cnt_reg - 3'd1;
                    end
                end
                PH_KEY:
                begin
                    key_next[{key_idx_reg, 3'b000} +: 8] =
                        key_reg[{key_idx_reg, 3'b000} +: 8] | b;
                    if (key_idx_reg == KEY_LAST)
                    begin
                        hdr_done = 1'b1;
                    end
                    else
                    begin
                        key_idx_next = key_idx_reg + 2'd1;
                    end
                end
                PH_DATA:
                begin
                    key_idx_next      = key_idx_reg + 2'd1;
                    remain_next       = remain_reg - {{(LEN_W-1){1'b0}}, 1'b1};
                    res_valid         = 1'b1;
                    res.payload_byte  = b ^ key_byte;
                    res.payload_valid = 1'b1;
                    res.frame_last    = (remain_next == '0);
                    if (remain_next == '0)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                default:
                begin
                    if (b[3:0] == OPC_CLOSE)
                    begin
                        closed_next    = 1'b1;
                        phase_next     = PH_HDR0;
                        res_valid      = 1'b1;
                        res.close_seen = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_HDR1;
                    end
                end
            endcase

            if (len_known)
            begin
                if (masked_next)
                begin
                    phase_next   = PH_KEY;
                    key_idx_next = '0;
                    key_next     = '0;
                end
                else
                begin
                    hdr_done = 1'b1;
                end
            end

            if (hdr_done)
            begin
                key_idx_next = '0;
                if (remain_next == '0)
                begin
                    phase_next     = PH_HDR0;
                    res_valid      = 1'b1;
                    res.frame_last = 1'b1;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            remain_reg  <= '0;
            ext_cnt_reg <= '0;
            masked_reg  <= 1'b0;
            key_reg     <= '0;
            key_idx_reg <= '0;
            closed_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            remain_reg  <= remain_next;
            ext_cnt_reg <= ext_cnt_next;
            masked_reg  <= masked_next;
            key_reg     <= key_next;
            key_idx_reg <= key_idx_next;
            closed_reg  <= closed_next;
        end
    end

    `WSD_ASSERT_SAME(a_closed_silent, clk, rst_n, closed_reg && !item.restart, !res_valid,
        "result produced after a close frame")
    `WSD_ASSERT_SAME(a_payload_in_data, clk, rst_n, res_valid && res.payload_valid,
        phase_reg == PH_DATA && remain_reg != '0, "payload byte outside the payload phase")
    `WSD_ASSERT_NEXT(a_last_ends_frame, clk, rst_n, fire && res_valid && res.frame_last,
        phase_reg == PH_HDR0, "frame end did not return to the first header byte")
    `WSD_ASSERT_NEXT(a_close_latches, clk, rst_n, fire && res_valid && res.close_seen,
        closed_reg, "close frame did not stop the parser")

endmodule

`default_nettype wire

// ----- hdl/websocket_frame_deframer.sv -----
// Top level of the WebSocket frame deframer: input register, parser and result register.
//
// Usage: received connection bytes enter on the rx channel, one byte per item,
// with restart set to begin a new connection (that byte is dropped). Frame
// payload bytes leave on the payload channel, unmasked, with frame_last on the
// final byte of each frame. A zero-length frame gives one item with
// payload_valid low and frame_last high. A close opcode gives one item with
// close_seen high, after which bytes give no item until a restart.
// Header bytes and ignored bytes give no item.
// Path: an item that gives a result passes the input register, then the
// result register behind the parser logic, before it is on the payload
// channel; a result that is not taken holds the parser back.
// Throughput: one byte per cycle while the payload side takes results, set by
// the parser update with its 64-bit length decrement and compare.
// Reset: rst_n clears the parser to wait for the first header byte of a frame
// and empties both registers.
// Stall: while the result register holds an item that is not taken, the input
// register still accepts one more byte; then rx ready drops until the payload
// side takes the result.
`default_nettype none

module websocket_frame_deframer (
    input  wire logic clk,
    input  wire logic rst_n,
    wsd_in_if.sink    rx,
    wsd_out_if.source tx
);
    import wsd_pkg::*;

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg, in_item_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;

    logic      go;
    logic      res_valid;
    out_item_t res;

    assign go       = in_valid_reg && (!out_valid_reg || tx.ready);
    assign rx.ready = !in_valid_reg || go;

    wsd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (go),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_item_next   = in_item_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (rx.valid && rx.ready)
        begin
            in_valid_next        = 1'b1;
            in_item_next.rx_byte = rx.rx_byte;
            in_item_next.restart = rx.restart;
        end
        else if (go)
        begin
            in_valid_next = 1'b0;
        end

        if (go && res_valid)
        begin
            out_valid_next = 1'b1;
            out_item_next  = res;
        end
        else if (tx.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    assign tx.valid         = out_valid_reg;
    assign tx.payload_byte  = out_item_reg.payload_byte;
    assign tx.payload_valid = out_item_reg.payload_valid;
    assign tx.frame_last    = out_item_reg.frame_last;
    assign tx.close_seen    = out_item_reg.close_seen;

endmodule

`default_nettype wire
